[rtl/core/tcci_pkg.sv]
// Shared types, codes and helpers for the test chip command interface.
// No dependencies; every other file of the block but tcci_ram imports this package.
package tcci_pkg;

  // Default size of the configuration byte store and the width of its index.
  localparam int SETTING_ENTRIES_DEF = 45;
  localparam int IDX_W = 6;

  // Event kinds carried by an input word.
  typedef enum logic [2:0] {
    KIND_CLOCK = 3'd0,
    KIND_RESET = 3'd1,
    KIND_ADC   = 3'd2,
    KIND_CMP   = 3'd3,
    KIND_TIME  = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_e;

  // Command machine states; the encoding is the reported state code.
  typedef enum logic [3:0] {
    ST_RESET    = 4'd0,
    ST_IDLE     = 4'd1,
    ST_WR_MODE  = 4'd2,
    ST_WR_ADDR  = 4'd3,
    ST_WR_VALUE = 4'd4,
    ST_WR_DONE  = 4'd5,
    ST_WR_ALL   = 4'd6,
    ST_RD_MODE  = 4'd7,
    ST_RD_ADDR  = 4'd8,
    ST_RD_DONE  = 4'd9,
    ST_RD_ALL   = 4'd10,
    ST_ADC      = 4'd11,
    ST_CMP      = 4'd12
  } state_e;

  // Low-nibble opcodes accepted in idle.
  localparam logic [3:0] OP_IDLE  = 4'h0;
  localparam logic [3:0] OP_CMP   = 4'hC;
  localparam logic [3:0] OP_ADC   = 4'hD;
  localparam logic [3:0] OP_WRITE = 4'hE;
  localparam logic [3:0] OP_READ  = 4'hF;

  // Fixed values driven on the data line.
  localparam logic [7:0] RESET_MARK    = 8'hA5;
  localparam logic [7:0] ECHO_WR_MODE  = 8'hE0;
  localparam logic [7:0] ECHO_WR_ADDR  = 8'hE1;
  localparam logic [7:0] ECHO_WR_VALUE = 8'hE2;
  localparam logic [7:0] ECHO_RD_MODE  = 8'hF0;

  // Configuration register indexes.
  localparam logic CFG_ADC_DELAY = 1'b0;
  localparam logic CFG_CMP_DELAY = 1'b1;

  typedef struct packed {
    kind_e       kind;
    logic        command_flag;
    logic [7:0]  bus_byte;
    logic        pin_level;
    logic [5:0]  adc_sample;
    logic [31:0] elapsed_ns;
  } item_t;

  typedef struct packed {
    logic        valid_flag;
    logic [7:0]  data_byte;
    logic [3:0]  state_code;
    logic [31:0] protocol_error_count;
    logic [31:0] unsupported_count;
    logic [31:0] bad_address_count;
    logic [31:0] edge_count;
    logic [31:0] operation_step;
  } result_t;

  // Request from the command machine to the byte store.
  typedef struct packed {
    logic             we;
    logic             clear;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_req_t;

  // Bit order reversal of a 6-bit converter code.
  function automatic logic [5:0] rev6(input logic [5:0] v);
    logic [5:0] r;
    for (int i = 0; i < 6; i++) begin
      r[5-i] = v[i];
    end
    return r;
  endfunction

endpackage

[rtl/core/tcci_item_if.sv]
// Input channel of the command interface: one event word per handshake.
// Depends on tcci_pkg for field widths.
interface tcci_item_if import tcci_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        command_flag;
  logic [7:0]  bus_byte;
  logic        pin_level;
  logic [5:0]  adc_sample;
  logic [31:0] elapsed_ns;

  modport source (output valid, kind, command_flag, bus_byte, pin_level, adc_sample,
                  elapsed_ns, input ready);
  modport sink (input valid, kind, command_flag, bus_byte, pin_level, adc_sample,
                elapsed_ns, output ready);
endinterface

[rtl/core/tcci_result_if.sv]
// Output channel of the command interface: one result word per handshake.
// Depends on tcci_pkg for field widths.
interface tcci_result_if import tcci_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        valid_flag;
  logic [7:0]  data_byte;
  logic [3:0]  state_code;
  logic [31:0] protocol_error_count;
  logic [31:0] unsupported_count;
  logic [31:0] bad_address_count;
  logic [31:0] edge_count;
  logic [31:0] operation_step;

  modport source (output valid, valid_flag, data_byte, state_code, protocol_error_count,
                  unsupported_count, bad_address_count, edge_count, operation_step,
                  input ready);
  modport sink (input valid, valid_flag, data_byte, state_code, protocol_error_count,
                unsupported_count, bad_address_count, edge_count, operation_step,
                output ready);
endinterface

[rtl/core/tcci_cfg_if.sv]
// Configuration write channel: register index and 32-bit write data.
// Depends on tcci_pkg only by convention; no package items are needed here.
interface tcci_cfg_if import tcci_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/test_chip_command_interface.sv]
// Top level of the test chip command interface: input word register, command
// engine, configuration byte store and result register.
// Depends on tcci_pkg, the three channel interfaces, tcci_store and tcci_engine.
//
// Usage
//   item_i carries one event word per handshake: a clock edge (command strobe
//   and bus byte), a reset pin level, a new converter code, a new comparator
//   level, a span of elapsed nanoseconds, or a clear of the error counters.
//   result_o returns exactly one word per event: the output valid and data
//   lines, the state code and the five counters as they stand after the event.
//   cfg_i writes the converter delay (index 0) and comparator delay (index 1);
//   always ready, it relies on the user to write only while no event is in flight.
// Timing
//   An accepted word waits in the input register; its result is loaded into
//   the result register when the engine advances. The engine takes one word
//   per cycle unless the result stalls; the store is read ahead through its
//   registered read port, with a bypass for a write made at the same edge.
// Reset and stall
//   After rst_ni the engine sits in the reset state, data line 0xA5, store all
//   zero. When the receiver holds ready low, the finished result waits in the
//   result register while one more word is taken into the input register;
//   after that item_i.ready drops until the result is taken.
module test_chip_command_interface import tcci_pkg::*; #(
  parameter int SETTING_ENTRIES = SETTING_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcci_item_if.sink     item_i,
  tcci_result_if.source result_o,
  tcci_cfg_if.sink      cfg_i
);

  item_t            in_q;
  logic             in_valid_q;
  logic             in_accept;
  logic             advance;
  logic [7:0]       nxt_byte;
  result_t          out_q, result_d;
  logic             out_valid_q;
  logic [31:0]      adc_delay_q, cmp_delay_q;
  store_req_t       store_req;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       store_data;

  // The engine advances when it holds a word and the result register is free
  // or being emptied in this same cycle.
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign in_accept    = item_i.valid && item_i.ready;
  assign nxt_byte     = in_accept ? item_i.bus_byte : in_q.bus_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (in_accept) begin
      in_q.kind         <= kind_e'(item_i.kind);
      in_q.command_flag <= item_i.command_flag;
      in_q.bus_byte     <= item_i.bus_byte;
      in_q.pin_level    <= item_i.pin_level;
      in_q.adc_sample   <= item_i.adc_sample;
      in_q.elapsed_ns   <= item_i.elapsed_ns;
    end
  end

  // Configuration registers; they rely on the user to write only while the block is idle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_delay_q <= '0;
      cmp_delay_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ADC_DELAY: adc_delay_q <= cfg_i.data;
        CFG_CMP_DELAY: cmp_delay_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  tcci_store #(
    .SETTING_ENTRIES(SETTING_ENTRIES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_addr_i(rd_addr),
    .rd_data_o(store_data)
  );

  tcci_engine #(
    .SETTING_ENTRIES(SETTING_ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_q),
    .advance_i   (advance),
    .nxt_byte_i  (nxt_byte),
    .store_data_i(store_data),
    .adc_delay_i (adc_delay_q),
    .cmp_delay_i (cmp_delay_q),
    .result_o    (result_d),
    .store_req_o (store_req),
    .rd_addr_o   (rd_addr)
  );

  // Result register: loaded whenever the engine advances, emptied on a take.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.valid_flag           = out_q.valid_flag;
  assign result_o.data_byte            = out_q.data_byte;
  assign result_o.state_code           = out_q.state_code;
  assign result_o.protocol_error_count = out_q.protocol_error_count;
  assign result_o.unsupported_count    = out_q.unsupported_count;
  assign result_o.bad_address_count    = out_q.bad_address_count;
  assign result_o.edge_count           = out_q.edge_count;
  assign result_o.operation_step       = out_q.operation_step;

endmodule

[rtl/core/tcci_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/tcci_store.sv]
// Configuration byte store: RAM plus per-entry valid bits for the all-zero
// reset, and a write-to-read bypass. Depends on tcci_pkg and tcci_ram.
module tcci_store import tcci_pkg::*; #(
  parameter int SETTING_ENTRIES = SETTING_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_req_t       req_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  localparam int AW = (SETTING_ENTRIES > 1) ? $clog2(SETTING_ENTRIES) : 1;

  logic [SETTING_ENTRIES-1:0] valid_q;
  logic [AW-1:0]              rd_idx, wr_idx, rd_idx_q;
  logic                       byp_q;
  logic [7:0]                 byp_data_q;
  logic [7:0]                 ram_rdata;

  // Out-of-range read addresses only occur where the data is never used.
  assign rd_idx = (rd_addr_i < IDX_W'(SETTING_ENTRIES)) ? rd_addr_i[AW-1:0] : '0;
  assign wr_idx = req_i.addr[AW-1:0];

  tcci_ram #(
    .WIDTH(8),
    .DEPTH(SETTING_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(wr_idx),
    .wdata_i(req_i.data),
    .raddr_i(rd_idx),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      byp_q <= req_i.we && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= req_i.data;
    rd_idx_q   <= rd_idx;
  end

  // An entry never written since the last clear reads as zero.
  assign rd_data_o = !valid_q[rd_idx_q] ? 8'h00 : (byp_q ? byp_data_q : ram_rdata);

endmodule

[rtl/core/tcci_engine.sv]
// Command machine, counters and test timers; processes one registered event
// word per cycle while advance_i is high. Depends on tcci_pkg.
module tcci_engine import tcci_pkg::*; #(
  parameter int SETTING_ENTRIES = SETTING_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             advance_i,
  input  logic [7:0]       nxt_byte_i,
  input  logic [7:0]       store_data_i,
  input  logic [31:0]      adc_delay_i,
  input  logic [31:0]      cmp_delay_i,
  output result_t          result_o,
  output store_req_t       store_req_o,
  output logic [IDX_W-1:0] rd_addr_o
);

  state_e           state_q, state_d, cur, nxt_state;
  logic             released_q, released_d;
  logic [IDX_W-1:0] idx_q, idx_d, addr_q, addr_d, nxt_idx;
  logic [5:0]       adc_code_q, adc_code_d;
  logic             cmp_lvl_q, cmp_lvl_d;
  logic             adc_wait_q, adc_wait_d, cmp_wait_q, cmp_wait_d;
  logic [63:0]      now_q, now_d, adc_due_q, adc_due_d, cmp_due_q, cmp_due_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       odata_q, odata_d;
  logic [31:0]      proto_q, proto_d, unsup_q, unsup_d, badaddr_q, badaddr_d;
  logic [31:0]      edges_q, edges_d, step_q, step_d;
  logic             idle_now;
  logic             cmd;
  logic [7:0]       b;

  assign cmd = item_i.command_flag;
  assign b   = item_i.bus_byte;

  always_comb begin
    state_d     = state_q;
    released_d  = released_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    adc_code_d  = adc_code_q;
    cmp_lvl_d   = cmp_lvl_q;
    adc_wait_d  = adc_wait_q;
    cmp_wait_d  = cmp_wait_q;
    now_d       = now_q;
    adc_due_d   = adc_due_q;
    cmp_due_d   = cmp_due_q;
    ovalid_d    = ovalid_q;
    odata_d     = odata_q;
    proto_d     = proto_q;
    unsup_d     = unsup_q;
    badaddr_d   = badaddr_q;
    edges_d     = edges_q;
    step_d      = step_q;
    idle_now    = 1'b0;
    cur         = state_q;
    store_req_o = '{we: 1'b0, clear: 1'b0, addr: idx_q, data: b};

    unique case (item_i.kind)
      KIND_CLOCK: begin
        edges_d = edges_q + 32'd1;
        if (!released_q) begin
          state_d  = ST_RESET;
          ovalid_d = 1'b0;
          odata_d  = RESET_MARK;
        end else begin
          // Leaving reset: this edge enters idle and is then treated as idle.
          if (state_q == ST_RESET) begin
            state_d    = ST_IDLE;
            idx_d      = '0;
            addr_d     = '0;
            adc_wait_d = 1'b0;
            cmp_wait_d = 1'b0;
            step_d     = '0;
            ovalid_d   = 1'b0;
            odata_d    = 8'h00;
            cur        = ST_IDLE;
          end
          unique case (cur)
            ST_IDLE: begin
              ovalid_d = 1'b0;
              odata_d  = 8'h00;
              if (cmd) begin
                if (b[7:4] != 4'h0) begin
                  proto_d = proto_d + 32'd1;
                end else begin
                  step_d = '0;
                  idx_d  = '0;
                  unique case (b[3:0])
                    OP_IDLE:  idle_now = 1'b1;
                    OP_WRITE: state_d = ST_WR_MODE;
                    OP_READ:  state_d = ST_RD_MODE;
                    OP_ADC: begin
                      state_d    = ST_ADC;
                      adc_wait_d = 1'b1;
                      adc_due_d  = now_q + {32'h0, adc_delay_i};
                      if (adc_delay_i == 32'h0) begin
                        odata_d    = {2'b00, rev6(adc_code_q)};
                        adc_wait_d = 1'b0;
                      end
                    end
                    OP_CMP: begin
                      state_d    = ST_CMP;
                      cmp_wait_d = 1'b1;
                      cmp_due_d  = now_q + {32'h0, cmp_delay_i};
                      if (cmp_delay_i == 32'h0) begin
                        odata_d    = {7'h00, cmp_lvl_q};
                        cmp_wait_d = 1'b0;
                      end
                    end
                    default: begin
                      unsup_d  = unsup_q + 32'd1;
                      idle_now = 1'b1;
                    end
                  endcase
                end
              end
            end
            ST_WR_MODE, ST_RD_MODE: begin
              if (cmd) begin
                proto_d = proto_q + 32'd1;
              end else begin
                step_d   = step_d + 32'd1;
                ovalid_d = 1'b0;
                odata_d  = (cur == ST_WR_MODE) ? ECHO_WR_MODE : ECHO_RD_MODE;
                idx_d    = '0;
                if (b[0]) begin
                  state_d = (cur == ST_WR_MODE) ? ST_WR_ALL : ST_RD_ALL;
                end else begin
                  state_d = (cur == ST_WR_MODE) ? ST_WR_ADDR : ST_RD_ADDR;
                end
              end
            end
            ST_WR_ADDR, ST_RD_ADDR: begin
              if (cmd) begin
                proto_d = proto_q + 32'd1;
              end else begin
                step_d = step_d + 32'd1;
                if (32'(b) >= 32'(SETTING_ENTRIES)) begin
                  badaddr_d = badaddr_q + 32'd1;
                  idle_now  = 1'b1;
                end else if (cur == ST_WR_ADDR) begin
                  addr_d   = b[IDX_W-1:0];
                  ovalid_d = 1'b0;
                  odata_d  = ECHO_WR_ADDR;
                  state_d  = ST_WR_VALUE;
                end else begin
                  addr_d   = b[IDX_W-1:0];
                  ovalid_d = 1'b1;
                  odata_d  = store_data_i;
                  state_d  = ST_RD_DONE;
                end
              end
            end
            ST_WR_VALUE: begin
              if (cmd) begin
                proto_d = proto_q + 32'd1;
              end else begin
                step_d         = step_d + 32'd1;
                store_req_o.we = 1'b1;
                store_req_o.addr = addr_q;
                ovalid_d       = 1'b0;
                odata_d        = ECHO_WR_VALUE;
                state_d        = ST_WR_DONE;
              end
            end
            ST_WR_DONE, ST_RD_DONE: begin
              if (cmd) begin
                proto_d = proto_q + 32'd1;
              end else begin
                step_d   = step_d + 32'd1;
                idle_now = 1'b1;
              end
            end
            ST_WR_ALL: begin
              if (cmd) begin
                proto_d = proto_q + 32'd1;
              end else begin
                step_d   = step_d + 32'd1;
                ovalid_d = 1'b0;
                if (32'(idx_q) < 32'(SETTING_ENTRIES)) begin
                  store_req_o.we = 1'b1;
                  odata_d        = 8'(idx_q);
                  idx_d          = idx_q + IDX_W'(1);
                end else if (32'(idx_q) == 32'(SETTING_ENTRIES)) begin
                  odata_d = 8'(SETTING_ENTRIES - 1);
                  idx_d   = idx_q + IDX_W'(1);
                end else begin
                  idle_now = 1'b1;
                end
              end
            end
            ST_RD_ALL: begin
              if (cmd) begin
                proto_d = proto_q + 32'd1;
              end else begin
                step_d = step_d + 32'd1;
                if (32'(idx_q) < 32'(SETTING_ENTRIES)) begin
                  ovalid_d = 1'b1;
                  odata_d  = store_data_i;
                  idx_d    = idx_q + IDX_W'(1);
                end else if (32'(idx_q) == 32'(SETTING_ENTRIES)) begin
                  ovalid_d = 1'b0;
                  idx_d    = idx_q + IDX_W'(1);
                end else begin
                  idle_now = 1'b1;
                end
              end
            end
            ST_ADC, ST_CMP: begin
              ovalid_d = 1'b0;
              if (cmd) begin
                if (b == {4'h0, OP_IDLE}) begin
                  idle_now = 1'b1;
                end else begin
                  proto_d = proto_q + 32'd1;
                end
              end
            end
            default: begin
              proto_d  = proto_q + 32'd1;
              idle_now = 1'b1;
            end
          endcase
        end
      end
      KIND_RESET: begin
        if (item_i.pin_level) begin
          released_d = 1'b1;
        end else begin
          if (released_q) begin
            edges_d = '0;
          end
          released_d        = 1'b0;
          ovalid_d          = 1'b0;
          odata_d           = RESET_MARK;
          idx_d             = '0;
          addr_d            = '0;
          adc_wait_d        = 1'b0;
          cmp_wait_d        = 1'b0;
          step_d            = '0;
          state_d           = ST_RESET;
          store_req_o.clear = 1'b1;
        end
      end
      KIND_ADC: begin
        adc_code_d = item_i.adc_sample;
        if (released_q && state_q == ST_ADC) begin
          ovalid_d   = 1'b0;
          adc_wait_d = 1'b1;
          adc_due_d  = now_q + {32'h0, adc_delay_i};
          if (adc_delay_i == 32'h0) begin
            odata_d    = {2'b00, rev6(adc_code_d)};
            adc_wait_d = 1'b0;
          end
        end
      end
      KIND_CMP: begin
        cmp_lvl_d = item_i.pin_level;
        if (released_q && state_q == ST_CMP) begin
          ovalid_d   = 1'b0;
          cmp_wait_d = 1'b1;
          cmp_due_d  = now_q + {32'h0, cmp_delay_i};
          if (cmp_delay_i == 32'h0) begin
            odata_d    = {7'h00, cmp_lvl_d};
            cmp_wait_d = 1'b0;
          end
        end
      end
      KIND_TIME: begin
        now_d = now_q + {32'h0, item_i.elapsed_ns};
        if (adc_wait_q && state_q == ST_ADC && now_d >= adc_due_q) begin
          odata_d    = {2'b00, rev6(adc_code_q)};
          adc_wait_d = 1'b0;
        end
        if (cmp_wait_q && state_q == ST_CMP && now_d >= cmp_due_q) begin
          odata_d    = {7'h00, cmp_lvl_q};
          cmp_wait_d = 1'b0;
        end
      end
      KIND_CLEAR: begin
        proto_d   = '0;
        unsup_d   = '0;
        badaddr_d = '0;
      end
      default: begin
      end
    endcase

    // Return to idle is always the last action of the branch that asks for it.
    if (idle_now) begin
      state_d    = ST_IDLE;
      idx_d      = '0;
      addr_d     = '0;
      adc_wait_d = 1'b0;
      cmp_wait_d = 1'b0;
      step_d     = '0;
      ovalid_d   = 1'b0;
      odata_d    = 8'h00;
    end

    if (!advance_i) begin
      store_req_o.we    = 1'b0;
      store_req_o.clear = 1'b0;
    end
  end

  // The store is read ahead through its registered port, at the address the next word will need.
  assign nxt_state = advance_i ? state_d : state_q;
  assign nxt_idx   = advance_i ? idx_d : idx_q;
  assign rd_addr_o = (nxt_state == ST_RD_ALL) ? nxt_idx : nxt_byte_i[IDX_W-1:0];

  always_comb begin
    result_o.valid_flag           = ovalid_d;
    result_o.data_byte            = odata_d;
    result_o.state_code           = state_d;
    result_o.protocol_error_count = proto_d;
    result_o.unsupported_count    = unsup_d;
    result_o.bad_address_count    = badaddr_d;
    result_o.edge_count           = edges_d;
    result_o.operation_step       = step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RESET;
      released_q <= 1'b0;
      idx_q      <= '0;
      addr_q     <= '0;
      adc_code_q <= '0;
      cmp_lvl_q  <= 1'b0;
      adc_wait_q <= 1'b0;
      cmp_wait_q <= 1'b0;
      now_q      <= '0;
      adc_due_q  <= '0;
      cmp_due_q  <= '0;
      ovalid_q   <= 1'b0;
      odata_q    <= RESET_MARK;
      proto_q    <= '0;
      unsup_q    <= '0;
      badaddr_q  <= '0;
      edges_q    <= '0;
      step_q     <= '0;
    end else if (advance_i) begin
      state_q    <= state_d;
      released_q <= released_d;
      idx_q      <= idx_d;
      addr_q     <= addr_d;
      adc_code_q <= adc_code_d;
      cmp_lvl_q  <= cmp_lvl_d;
      adc_wait_q <= adc_wait_d;
      cmp_wait_q <= cmp_wait_d;
      now_q      <= now_d;
      adc_due_q  <= adc_due_d;
      cmp_due_q  <= cmp_due_d;
      ovalid_q   <= ovalid_d;
      odata_q    <= odata_d;
      proto_q    <= proto_d;
      unsup_q    <= unsup_d;
      badaddr_q  <= badaddr_d;
      edges_q    <= edges_d;
      step_q     <= step_d;
    end
  end

  // A clock edge seen while the reset pin is low always lands in reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && item_i.kind == KIND_CLOCK && !released_q) |=> (state_q == ST_RESET))
    else $error("clock edge under reset pin did not enter reset state");

  // A pending converter or comparator result only exists in its test state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adc_wait_q |-> (state_q == ST_ADC))
    else $error("adc result pending outside adc test");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_wait_q |-> (state_q == ST_CMP))
    else $error("comparator result pending outside comparator test");

  // Idle is only reached through the return-to-idle path or the exit from reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (idx_q == '0 && step_q == '0))
    else $error("idle state with nonzero index or step count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= 32'(SETTING_ENTRIES + 1))
    else $error("store index ran past the end of the store");

endmodule

[tb/test_chip_command_interface_tb.sv]
// Self-checking testbench for the test chip command interface.
// Depends on tcci_pkg, the three channel interfaces and test_chip_command_interface.
// A built-in predictor computes every result word; a monitor compares each field.
module test_chip_command_interface_tb;
  import tcci_pkg::*;

  localparam int ENTRIES = SETTING_ENTRIES_DEF;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 185;
  localparam int SETTLE_LIMIT = 20000;

  // One input word as the testbench holds it. The kind field is kept as a
  // plain vector so that the two undefined kind codes can be sent as well.
  typedef struct packed {
    logic [2:0]  kind;
    logic        command_flag;
    logic [7:0]  bus_byte;
    logic        pin_level;
    logic [5:0]  adc_sample;
    logic [31:0] elapsed_ns;
  } chip_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tcci_item_if   item_bus ();
  tcci_result_if result_bus ();
  tcci_cfg_if    cfg_bus ();

  test_chip_command_interface DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // Words waiting to be driven, and the result words that the predictor has
  // computed for words already accepted, oldest first.
  chip_event_t event_backlog[$];
  result_t     awaited_lines[$];

  int words_queued = 0;
  int words_sent = 0;
  int words_checked = 0;
  int settings_used = 0;
  int error_count = 0;

  // Copy of the port's state as the predictor sees it.
  logic [31:0] adc_delay, cmp_delay;
  state_e      mdl_state;
  bit          mdl_released;
  logic [7:0]  mdl_store [ENTRIES];
  int          mdl_index;
  logic [5:0]  mdl_addr;
  logic [5:0]  mdl_adc_code;
  bit          mdl_cmp_level;
  bit          adc_armed, cmp_pending;
  logic [63:0] now_ns, adc_due, cmp_due;
  bit          out_valid;
  logic [7:0]  out_data;
  logic [31:0] proto_errs, unsup_ops, bad_addrs, edge_total, step_total;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [5:0] flip6(input logic [5:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5]};
  endfunction

  function automatic void enter_idle();
    mdl_state = ST_IDLE;
    mdl_index = 0;
    mdl_addr = '0;
    adc_armed = 1'b0;
    cmp_pending = 1'b0;
    step_total = '0;
    out_valid = 1'b0;
    out_data = 8'h00;
  endfunction

  // A zero delay answers at once; otherwise the answer waits for time words.
  function automatic void arm_adc();
    adc_armed = 1'b1;
    adc_due = now_ns + {32'h0, adc_delay};
    if (adc_delay == 32'h0) begin
      out_data = {2'b00, flip6(mdl_adc_code)};
      adc_armed = 1'b0;
    end
  endfunction

  function automatic void arm_cmp();
    cmp_pending = 1'b1;
    cmp_due = now_ns + {32'h0, cmp_delay};
    if (cmp_delay == 32'h0) begin
      out_data = {7'h0, mdl_cmp_level};
      cmp_pending = 1'b0;
    end
  endfunction

  // A strobe during a data cycle is a protocol error and the cycle is lost.
  function automatic bit take_data(input bit strobe);
    if (strobe) begin
      proto_errs++;
      return 1'b0;
    end
    step_total++;
    return 1'b1;
  endfunction

  function automatic result_t port_response(input chip_event_t ev);
    bit         cmd;
    bit         wr;
    logic [7:0] b;
    result_t    r;
    cmd = ev.command_flag;
    b = ev.bus_byte;
    case (ev.kind)
      KIND_CLOCK: begin
        edge_total++;
        if (!mdl_released) begin
          mdl_state = ST_RESET;
          out_valid = 1'b0;
          out_data = RESET_MARK;
        end else begin
          // The first edge after release enters idle and is then an idle edge.
          if (mdl_state == ST_RESET) enter_idle();
          case (mdl_state)
            ST_IDLE: begin
              out_valid = 1'b0;
              out_data = 8'h00;
              if (cmd) begin
                if (b[7:4] != 4'h0) begin
                  proto_errs++;
                end else begin
                  step_total = '0;
                  mdl_index = 0;
                  case (b[3:0])
                    OP_IDLE:  enter_idle();
                    OP_WRITE: mdl_state = ST_WR_MODE;
                    OP_READ:  mdl_state = ST_RD_MODE;
                    OP_ADC: begin
                      mdl_state = ST_ADC;
                      arm_adc();
                    end
                    OP_CMP: begin
                      mdl_state = ST_CMP;
                      arm_cmp();
                    end
                    default: begin
                      unsup_ops++;
                      enter_idle();
                    end
                  endcase
                end
              end
            end
            ST_WR_MODE, ST_RD_MODE: begin
              if (take_data(cmd)) begin
                wr = (mdl_state == ST_WR_MODE);
                out_valid = 1'b0;
                out_data = wr ? ECHO_WR_MODE : ECHO_RD_MODE;
                mdl_index = 0;
                if (b[0]) mdl_state = wr ? ST_WR_ALL : ST_RD_ALL;
                else mdl_state = wr ? ST_WR_ADDR : ST_RD_ADDR;
              end
            end
            ST_WR_ADDR, ST_RD_ADDR: begin
              if (take_data(cmd)) begin
                if (b >= ENTRIES) begin
                  bad_addrs++;
                  enter_idle();
                end else if (mdl_state == ST_WR_ADDR) begin
                  mdl_addr = b[5:0];
                  out_valid = 1'b0;
                  out_data = ECHO_WR_ADDR;
                  mdl_state = ST_WR_VALUE;
                end else begin
                  mdl_addr = b[5:0];
                  out_valid = 1'b1;
                  out_data = mdl_store[b];
                  mdl_state = ST_RD_DONE;
                end
              end
            end
            ST_WR_VALUE: begin
              if (take_data(cmd)) begin
                mdl_store[mdl_addr] = b;
                out_valid = 1'b0;
                out_data = ECHO_WR_VALUE;
                mdl_state = ST_WR_DONE;
              end
            end
            ST_WR_DONE, ST_RD_DONE: begin
              if (take_data(cmd)) enter_idle();
            end
            ST_WR_ALL: begin
              if (take_data(cmd)) begin
                out_valid = 1'b0;
                if (mdl_index < ENTRIES) begin
                  mdl_store[mdl_index] = b;
                  out_data = 8'(mdl_index);
                  mdl_index++;
                end else if (mdl_index == ENTRIES) begin
                  out_data = 8'(ENTRIES - 1);
                  mdl_index++;
                end else begin
                  enter_idle();
                end
              end
            end
            ST_RD_ALL: begin
              if (take_data(cmd)) begin
                if (mdl_index < ENTRIES) begin
                  out_valid = 1'b1;
                  out_data = mdl_store[mdl_index];
                  mdl_index++;
                end else if (mdl_index == ENTRIES) begin
                  // Tail cycle: valid drops, the data line keeps its value.
                  out_valid = 1'b0;
                  mdl_index++;
                end else begin
                  enter_idle();
                end
              end
            end
            ST_ADC, ST_CMP: begin
              out_valid = 1'b0;
              if (cmd) begin
                if (b == 8'h00) enter_idle();
                else proto_errs++;
              end
            end
            default: begin
              proto_errs++;
              enter_idle();
            end
          endcase
        end
      end
      KIND_RESET: begin
        if (ev.pin_level) begin
          mdl_released = 1'b1;
        end else begin
          // Only a falling pin clears the edge count, not a repeated low.
          if (mdl_released) edge_total = '0;
          mdl_released = 1'b0;
          out_valid = 1'b0;
          out_data = RESET_MARK;
          mdl_index = 0;
          mdl_addr = '0;
          adc_armed = 1'b0;
          cmp_pending = 1'b0;
          step_total = '0;
          mdl_state = ST_RESET;
          foreach (mdl_store[i]) mdl_store[i] = 8'h00;
        end
      end
      KIND_ADC: begin
        mdl_adc_code = ev.adc_sample;
        if (mdl_released && mdl_state == ST_ADC) begin
          out_valid = 1'b0;
          arm_adc();
        end
      end
      KIND_CMP: begin
        mdl_cmp_level = ev.pin_level;
        if (mdl_released && mdl_state == ST_CMP) begin
          out_valid = 1'b0;
          arm_cmp();
        end
      end
      KIND_TIME: begin
        now_ns = now_ns + {32'h0, ev.elapsed_ns};
        if (adc_armed && mdl_state == ST_ADC && now_ns >= adc_due) begin
          out_data = {2'b00, flip6(mdl_adc_code)};
          adc_armed = 1'b0;
        end
        if (cmp_pending && mdl_state == ST_CMP && now_ns >= cmp_due) begin
          out_data = {7'h0, mdl_cmp_level};
          cmp_pending = 1'b0;
        end
      end
      KIND_CLEAR: begin
        proto_errs = '0;
        unsup_ops = '0;
        bad_addrs = '0;
      end
      default: ;
    endcase
    r.valid_flag = out_valid;
    r.data_byte = out_data;
    r.state_code = mdl_state;
    r.protocol_error_count = proto_errs;
    r.unsupported_count = unsup_ops;
    r.bad_address_count = bad_addrs;
    r.edge_count = edge_total;
    r.operation_step = step_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Fields that the kind does not use are random, so that the block is seen
  // to ignore them.
  function automatic chip_event_t any_event(input logic [2:0] k);
    chip_event_t e;
    e.kind = k;
    e.command_flag = 1'($urandom);
    e.bus_byte = 8'($urandom);
    e.pin_level = 1'($urandom);
    e.adc_sample = 6'($urandom);
    e.elapsed_ns = $urandom;
    return e;
  endfunction

  function automatic void queue_event(input chip_event_t e);
    event_backlog.push_back(e);
    words_queued++;
  endfunction

  function automatic void push_edge(input bit strobe, input logic [7:0] b);
    chip_event_t e;
    e = any_event(KIND_CLOCK);
    e.command_flag = strobe;
    e.bus_byte = b;
    queue_event(e);
  endfunction

  // A data cycle; now and then a stray strobe is slipped in ahead of it.
  function automatic void push_data(input logic [7:0] b);
    if ($urandom_range(0, 99) < 8) push_edge(1'b1, 8'($urandom));
    push_edge(1'b0, b);
  endfunction

  function automatic void push_pin(input bit level);
    chip_event_t e;
    e = any_event(KIND_RESET);
    e.pin_level = level;
    queue_event(e);
  endfunction

  function automatic void push_adc(input logic [5:0] code);
    chip_event_t e;
    e = any_event(KIND_ADC);
    e.adc_sample = code;
    queue_event(e);
  endfunction

  function automatic void push_cmp(input bit level);
    chip_event_t e;
    e = any_event(KIND_CMP);
    e.pin_level = level;
    queue_event(e);
  endfunction

  function automatic void push_time(input logic [31:0] dt);
    chip_event_t e;
    e = any_event(KIND_TIME);
    e.elapsed_ns = dt;
    queue_event(e);
  endfunction

  // Idle and stall lengths: mostly none or short, a few long, and stretches
  // where neither side idles at all.
  bit quiet_run = 1'b0;

  function automatic int gap_len();
    int r;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(6, 30));
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("ERROR word %0d %s: got %0h, expected %0h", words_checked, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the backlog on the input channel. Each accepted word
  // goes through the predictor at the edge that accepts it.
  // ---------------------------------------------------------------------

  chip_event_t on_bus;
  int idle_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 299) == 0) quiet_run = !quiet_run;
      if (item_bus.valid && item_bus.ready) begin
        awaited_lines.push_back(port_response(on_bus));
        words_sent++;
      end
      // The slot is free when nothing is shown or the shown word just left.
      if (!item_bus.valid || item_bus.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          item_bus.valid <= 1'b0;
        end else if (event_backlog.size() > 0) begin
          on_bus = event_backlog.pop_front();
          item_bus.valid <= 1'b1;
          item_bus.kind <= on_bus.kind;
          item_bus.command_flag <= on_bus.command_flag;
          item_bus.bus_byte <= on_bus.bus_byte;
          item_bus.pin_level <= on_bus.pin_level;
          item_bus.adc_sample <= on_bus.adc_sample;
          item_bus.elapsed_ns <= on_bus.elapsed_ns;
          idle_left = gap_len();
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: takes result words under random back-pressure and checks each
  // field against the oldest predicted word.
  // ---------------------------------------------------------------------

  result_t want;
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        if (awaited_lines.size() == 0) begin
          flag_error("arrived with nothing predicted", 32'(result_bus.data_byte), 32'h0);
        end else begin
          want = awaited_lines.pop_front();
          if (result_bus.valid_flag !== want.valid_flag)
            flag_error("valid_flag", 32'(result_bus.valid_flag), 32'(want.valid_flag));
          if (result_bus.data_byte !== want.data_byte)
            flag_error("data_byte", 32'(result_bus.data_byte), 32'(want.data_byte));
          if (result_bus.state_code !== want.state_code)
            flag_error("state_code", 32'(result_bus.state_code), 32'(want.state_code));
          if (result_bus.protocol_error_count !== want.protocol_error_count)
            flag_error("protocol_error_count", result_bus.protocol_error_count,
                       want.protocol_error_count);
          if (result_bus.unsupported_count !== want.unsupported_count)
            flag_error("unsupported_count", result_bus.unsupported_count,
                       want.unsupported_count);
          if (result_bus.bad_address_count !== want.bad_address_count)
            flag_error("bad_address_count", result_bus.bad_address_count,
                       want.bad_address_count);
          if (result_bus.edge_count !== want.edge_count)
            flag_error("edge_count", result_bus.edge_count, want.edge_count);
          if (result_bus.operation_step !== want.operation_step)
            flag_error("operation_step", result_bus.operation_step, want.operation_step);
        end
        words_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------

  // The predictor takes the new delay at the edge that writes the register.
  task automatic set_delay(input logic which, input logic [31:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= which;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (which == CFG_ADC_DELAY) adc_delay = value;
    else cmp_delay = value;
  endtask

  // Waits until every queued word has been sent and answered, or the settle
  // limit runs out, then waits on so that the block is surely quiet.
  task automatic settle();
    int waited;
    waited = 0;
    while ((event_backlog.size() != 0 || item_bus.valid || awaited_lines.size() != 0 ||
            words_checked < words_queued) && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          p, r, n, start;
    logic [3:0]  op;
    logic [31:0] dt, adc_set, cmp_set;
    logic [7:0]  addr;
    chip_event_t e;

    // Every input is known from time zero, while reset is held low.
    rst_ni = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.kind = KIND_CLOCK;
    item_bus.command_flag = 1'b0;
    item_bus.bus_byte = 8'h00;
    item_bus.pin_level = 1'b0;
    item_bus.adc_sample = 6'h00;
    item_bus.elapsed_ns = 32'h0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_ADC_DELAY;
    cfg_bus.data = 32'h0;

    adc_delay = '0;
    cmp_delay = '0;
    mdl_state = ST_RESET;
    mdl_released = 1'b0;
    foreach (mdl_store[i]) mdl_store[i] = 8'h00;
    mdl_index = 0;
    mdl_addr = '0;
    mdl_adc_code = '0;
    mdl_cmp_level = 1'b0;
    adc_armed = 1'b0;
    cmp_pending = 1'b0;
    now_ns = '0;
    adc_due = '0;
    cmp_due = '0;
    out_valid = 1'b0;
    out_data = RESET_MARK;
    proto_errs = '0;
    unsup_ops = '0;
    bad_addrs = '0;
    edge_total = '0;
    step_total = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p < PHASES; p++) begin
      // Delay settings per phase: both extremes first, then a unit delay,
      // short ones that time words often reach, and full-range values.
      case (p)
        0: begin adc_set = 32'h0;         cmp_set = 32'hFFFF_FFFF; end
        1: begin adc_set = 32'hFFFF_FFFF; cmp_set = 32'h0;         end
        2: begin adc_set = 32'h1;         cmp_set = 32'h1;         end
        3: begin adc_set = $urandom_range(2, 200); cmp_set = $urandom_range(2, 200); end
        4: begin adc_set = $urandom;      cmp_set = $urandom_range(2, 200); end
        default: begin adc_set = $urandom_range(2, 200); cmp_set = $urandom; end
      endcase
      set_delay(CFG_ADC_DELAY, adc_set);
      set_delay(CFG_CMP_DELAY, cmp_set);
      settings_used++;

      if (p == 0) begin
        // Directed opening: an edge with the pin still low, release, a
        // single write and read at the last address with a stray strobe, an
        // address just past the store, an idle command with the high nibble
        // set, an unknown opcode and opcode zero, an immediate converter
        // answer and a test exit, undefined kinds, a clear, and the pin
        // pulled low twice.
        push_edge(1'b0, 8'h3C);
        push_pin(1'b1);
        push_edge(1'b1, {4'h0, OP_WRITE});
        push_edge(1'b0, 8'h00);
        push_edge(1'b1, 8'hFF);
        push_edge(1'b0, 8'(ENTRIES - 1));
        push_edge(1'b0, 8'hFF);
        push_edge(1'b0, 8'h00);
        push_edge(1'b1, {4'h0, OP_READ});
        push_edge(1'b0, 8'hFE);
        push_edge(1'b0, 8'(ENTRIES - 1));
        push_edge(1'b0, 8'h00);
        push_edge(1'b1, {4'h0, OP_WRITE});
        push_edge(1'b0, 8'h00);
        push_edge(1'b0, 8'(ENTRIES));
        push_edge(1'b1, 8'hF0);
        push_edge(1'b1, 8'h07);
        push_edge(1'b1, {4'h0, OP_IDLE});
        push_edge(1'b1, {4'h0, OP_ADC});
        push_adc(6'h3F);
        push_adc(6'h01);
        push_edge(1'b1, 8'h01);
        push_edge(1'b1, 8'h00);
        queue_event(any_event(3'd6));
        queue_event(any_event(3'd7));
        queue_event(any_event(KIND_CLEAR));
        push_pin(1'b0);
        push_pin(1'b0);
        push_pin(1'b1);
      end

      // Random part: mostly complete commands with random content, the rest
      // reset pulses, counter clears and loose words of any kind.
      start = words_queued;
      while (words_queued - start < WORDS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          op = (r < 20) ? OP_WRITE : OP_READ;
          push_edge(1'b1, {4'h0, op});
          push_data({7'($urandom), 1'b0});
          n = $urandom_range(0, 99);
          if (n < 80) addr = 8'($urandom_range(0, ENTRIES - 1));
          else if (n < 90) addr = 8'($urandom_range(ENTRIES, 255));
          else addr = n[0] ? 8'(ENTRIES - 1) : 8'(ENTRIES);
          push_data(addr);
          if (op == OP_WRITE) push_data(8'($urandom));
          push_data(8'($urandom));
        end else if (r < 45) begin
          // Whole-store transfer, including the two tail words.
          push_edge(1'b1, {4'h0, (r < 40) ? OP_WRITE : OP_READ});
          push_data({7'($urandom), 1'b1});
          repeat (ENTRIES + 2) push_data(8'($urandom));
        end else if (r < 75) begin
          push_edge(1'b1, {4'h0, (r < 60) ? OP_ADC : OP_CMP});
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0: push_adc(6'($urandom));
              1: push_cmp(1'($urandom));
              2, 3: begin
                r = $urandom_range(0, 99);
                if (r < 60) dt = $urandom_range(0, 64);
                else if (r < 80) dt = $urandom_range(0, 2000);
                else if (r < 92) dt = $urandom;
                else dt = r[0] ? 32'hFFFF_FFFF : 32'h0;
                push_time(dt);
              end
              4: push_edge(1'b0, 8'($urandom));
              default: push_edge(1'b1, 8'($urandom_range(1, 255)));
            endcase
          end
          push_edge(1'b1, 8'h00);
        end else if (r < 80) begin
          push_pin(1'b0);
          repeat ($urandom_range(0, 3)) push_edge(1'($urandom), 8'($urandom));
          if ($urandom_range(0, 9) < 3) push_pin(1'b0);
          push_pin(1'b1);
        end else if (r < 83) begin
          queue_event(any_event(KIND_CLEAR));
        end else begin
          // Loose word; a reset pin word here only ever raises the pin.
          e = any_event(3'($urandom_range(0, 7)));
          if (e.kind == KIND_RESET) e.pin_level = 1'b1;
          queue_event(e);
        end
      end
      settle();
    end

    if (awaited_lines.size() != 0)
      flag_error("result words never returned", awaited_lines.size(), 32'h0);

    $display("Summary: %0d words sent, %0d result words checked, %0d errors.",
             words_sent, words_checked, error_count);
    $display("Covered %0d delay settings, single and whole-store transfers, test modes.",
             settings_used);
    if (error_count == 0) begin
      $display("test_chip_command_interface_tb passed");
    end else begin
      $display("test_chip_command_interface_tb failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("Run limit reached before the last result word.");
    $display("test_chip_command_interface_tb failed");
    $finish;
  end

endmodule
